/* rtl/flash_version_log_slots_unit_assert.svh */
// Assertion macros used by the checker of the flash version log slot keeper.
`ifndef FLASH_VERSION_LOG_SLOTS_UNIT_ASSERT_SVH
`define FLASH_VERSION_LOG_SLOTS_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk and idle while reset is held.
`define FVLS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and idle while reset is held.
`define FVLS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/fvls_pkg.sv */
// Shared types, codes and defaults of the flash version log slot keeper.
package fvls_pkg;

    localparam int DATASET_BYTES_DEF = 32;
    localparam int PAGE_BYTES_DEF    = 256;
    localparam int SECTOR_BYTES_DEF  = 4096;
    localparam int FIRST_SLOT_DEF    = 8;
    localparam int LAST_SLOT_DEF     = 2047;

    localparam int SLOT_W = 11;
    localparam int IDX_W  = 8;

    localparam logic [7:0] HEADER_BYTE = 8'h7F;
    localparam logic [7:0] ALL_ONES    = 8'hFF;
    localparam logic [7:0] TOP_BIT     = 8'h80;

    // Register indexes on the configuration port (paddr bit 2).
    localparam logic REG_ID   = 1'b0;
    localparam logic REG_BASE = 1'b1;

    typedef enum logic [2:0] {
        CMD_ERASE  = 3'd0,
        CMD_HEADER = 3'd1,
        CMD_TRACK  = 3'd2,
        CMD_DATA   = 3'd3,
        CMD_READ   = 3'd4,
        CMD_REJECT = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        PH_ID    = 2'd0,
        PH_ZEROS = 2'd1,
        PH_ONES  = 2'd2,
        PH_BAD   = 2'd3
    } t_phase;

    typedef struct packed {
        logic             action;
        logic [7:0]       page_byte;
        logic             last_byte;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0] cur_slot;
        logic              needs_init;
        logic [IDX_W-1:0]  scan_index;
        t_phase            phase;
        logic [SLOT_W-1:0] scan_slot;
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic [31:0]       addr;
        logic [7:0]        data;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } t_result;

endpackage

/* rtl/fvls_step.sv */
// Next-state and command logic for one input item of the slot keeper.
module fvls_step #(
    parameter int DATASET_BYTES = fvls_pkg::DATASET_BYTES_DEF,
    parameter int PAGE_BYTES    = fvls_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES  = fvls_pkg::SECTOR_BYTES_DEF,
    parameter int FIRST_SLOT    = fvls_pkg::FIRST_SLOT_DEF,
    parameter int LAST_SLOT     = fvls_pkg::LAST_SLOT_DEF
) (
    input  fvls_pkg::t_state      i_state,
    input  fvls_pkg::t_item       i_item,
    input  logic [7:0]            i_id,
    input  logic [31:0]           i_base,
    output fvls_pkg::t_state      o_state,
    output fvls_pkg::t_result [2:0] o_res,
    output logic [1:0]            o_count
);

    localparam int SW = fvls_pkg::SLOT_W;
    localparam int IW = fvls_pkg::IDX_W;
    localparam logic [IW-1:0] FINAL_IDX = IW'(PAGE_BYTES - 1);
    localparam int START_I = (FIRST_SLOT / 8 < 1) ? 1 : FIRST_SLOT / 8;
    localparam logic [IW-1:0] START_IDX = IW'(START_I);
    localparam logic [SW-1:0] FIRST_S = SW'(FIRST_SLOT);
    localparam logic [SW-1:0] LAST_S = SW'(LAST_SLOT);
    localparam logic [SW-1:0] ALLZ_SLOT = SW'((PAGE_BYTES * 8 - 1) % 2048);
    localparam logic [8:0] DB = 9'(DATASET_BYTES);
    localparam int SECT_LG = $clog2(SECTOR_BYTES);

    logic [2:0]        lead;
    logic [11:0]       bit_pos;
    fvls_pkg::t_phase  sb_phase;
    logic [SW-1:0]     sb_slot;
    logic [SW-1:0]     save_pos;
    logic [SW-1:0]     sel_pos;
    logic [19:0]       offset;
    logic [31:0]       slot_addr;
    logic [31:0]       track_addr;
    logic [7:0]        track_data;
    logic [3:0]        track_sh;
    fvls_pkg::t_phase  end_phase;
    logic              load_ok;
    logic [SW-1:0]     load_pos;

    // Count leading zeros of the page byte, saturating at seven.
    always_comb begin
        lead = 3'd7;
        for (int i = 6; i >= 0; i--) begin
            if (i_item.page_byte[7-i]) begin
                lead = 3'(i);
            end
        end
        bit_pos = 12'({i_state.scan_index, 3'b000}) + 12'(lead) - 12'd1;
    end

    // One page byte against the scan state.
    always_comb begin
        sb_phase = i_state.phase;
        sb_slot  = i_state.scan_slot;
        case (i_state.phase)
            fvls_pkg::PH_ID: begin
                sb_phase = (i_item.page_byte == i_id) ? fvls_pkg::PH_ZEROS : fvls_pkg::PH_BAD;
            end
            fvls_pkg::PH_ZEROS: begin
                if (i_state.scan_index >= START_IDX && i_item.page_byte != 8'd0) begin
                    if (bit_pos < 12'(FIRST_S) ||
                        i_item.page_byte != (fvls_pkg::ALL_ONES >> lead)) begin
                        sb_phase = fvls_pkg::PH_BAD;
                    end else begin
                        sb_slot  = bit_pos[SW-1:0];
                        sb_phase = fvls_pkg::PH_ONES;
                    end
                end
            end
            fvls_pkg::PH_ONES: begin
                if (i_item.page_byte != fvls_pkg::ALL_ONES) begin
                    sb_phase = fvls_pkg::PH_BAD;
                end
            end
            default: begin
                sb_phase = fvls_pkg::PH_BAD;
            end
        endcase
    end

    // Judgment of the page when its last byte arrives.
    always_comb begin
        end_phase = (i_state.scan_index != FINAL_IDX) ? fvls_pkg::PH_BAD : sb_phase;
        load_ok   = (end_phase == fvls_pkg::PH_ONES) || (end_phase == fvls_pkg::PH_ZEROS);
        load_pos  = (end_phase == fvls_pkg::PH_ONES) ? sb_slot : ALLZ_SLOT;
    end

    // Slot addressing, shared between a save and a load.
    always_comb begin
        if (i_state.needs_init) begin
            save_pos = i_state.cur_slot;
        end else if (i_state.cur_slot < LAST_S) begin
            save_pos = i_state.cur_slot + SW'(1);
        end else begin
            save_pos = FIRST_S;
        end
        sel_pos    = i_item.action ? save_pos : load_pos;
        offset     = 20'(sel_pos) * 20'(DB);
        slot_addr  = i_base + 32'(offset);
        track_addr = i_base + 32'(sel_pos[SW-1:3]);
        track_sh   = 4'(sel_pos[2:0]) + 4'd1;
        track_data = fvls_pkg::ALL_ONES >> track_sh;
    end

    always_comb begin
        o_state = i_state;
        o_res   = '0;
        o_count = 2'd0;
        if (i_item.action) begin
            o_state.scan_index = '0;
            o_state.phase      = fvls_pkg::PH_ID;
            o_state.scan_slot  = '0;
            o_state.needs_init = 1'b0;
            o_state.cur_slot   = save_pos;
            o_res[2] = '{cmd: fvls_pkg::CMD_DATA, addr: slot_addr, data: 8'd0,
                         slot: save_pos, last: 1'b1};
            o_res[1] = '{cmd: fvls_pkg::CMD_TRACK, addr: track_addr, data: track_data,
                         slot: save_pos, last: 1'b0};
            if (save_pos == FIRST_S) begin
                o_res[0] = '{cmd: fvls_pkg::CMD_ERASE, addr: i_base, data: 8'd0,
                             slot: save_pos, last: 1'b0};
                o_res[1] = '{cmd: fvls_pkg::CMD_HEADER, addr: i_base,
                             data: fvls_pkg::HEADER_BYTE, slot: save_pos, last: 1'b0};
                o_count  = 2'd3;
            end else if (slot_addr[SECT_LG-1:0] == '0) begin
                o_res[0] = '{cmd: fvls_pkg::CMD_ERASE, addr: slot_addr, data: 8'd0,
                             slot: save_pos, last: 1'b0};
                o_count  = 2'd3;
            end else begin
                // No erase: the track write and the data write move down one place.
                o_res[0] = o_res[1];
                o_res[1] = o_res[2];
                o_res[2] = '0;
                o_count  = 2'd2;
            end
        end else if (!i_item.last_byte) begin
            if (i_state.scan_index >= FINAL_IDX) begin
                o_state.phase = fvls_pkg::PH_BAD;
            end else begin
                o_state.phase      = sb_phase;
                o_state.scan_slot  = sb_slot;
                o_state.scan_index = i_state.scan_index + IW'(1);
            end
        end else begin
            o_state.scan_index = '0;
            o_state.phase      = fvls_pkg::PH_ID;
            o_state.scan_slot  = '0;
            o_count            = 2'd1;
            if (load_ok) begin
                o_state.cur_slot   = load_pos;
                o_state.needs_init = 1'b0;
                o_res[0] = '{cmd: fvls_pkg::CMD_READ, addr: slot_addr, data: 8'd0,
                             slot: load_pos, last: 1'b1};
            end else begin
                o_res[0] = '{cmd: fvls_pkg::CMD_REJECT, addr: i_base, data: 8'd0,
                             slot: i_state.cur_slot, last: 1'b1};
            end
        end
    end

endmodule

/* rtl/flash_version_log_slots_unit.sv */
// Top level of the flash version log slot keeper (append log in one 64K block).
// Items pass through the input register, the command burst and the master-side output register.
// Throughput: one tracking page byte per cycle while no commands wait in the burst; a save of
// three commands holds the input until its burst has drained through the single output register.
// Reset (synchronous, i_rst_n low): slot 8 with init pending, scan cleared, id 0,
// block base 0x0001_0000, no item held and no result pending.
module flash_version_log_slots_unit #(
    parameter int DATASET_BYTES = fvls_pkg::DATASET_BYTES_DEF,
    parameter int PAGE_BYTES    = fvls_pkg::PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES  = fvls_pkg::SECTOR_BYTES_DEF,
    parameter int FIRST_SLOT    = fvls_pkg::FIRST_SLOT_DEF,
    parameter int LAST_SLOT     = fvls_pkg::LAST_SLOT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] page_byte
    input  logic        s_tuser,   // [0] action (0 load byte, 1 save)
    input  logic        s_tlast,   // last_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] address, [39:32] data_byte, [50:40] slot, rest 0
    output logic [2:0]  m_tuser,   // [2:0] command
    output logic        m_tlast,   // last
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW = fvls_pkg::SLOT_W;

    // Configuration registers. The block base keeps only its upper half, so it is
    // always 64K aligned.
    logic [7:0]  r_id;
    logic [15:0] r_base_hi;
    logic [31:0] base;

    // Input register: one accepted item waiting to be worked.
    logic             r_in_v;
    fvls_pkg::t_item  r_in;

    // Slot and scan state.
    fvls_pkg::t_state r_state;
    fvls_pkg::t_state n_state;

    // Command burst: up to three commands of one item, shifted out in order.
    fvls_pkg::t_result [2:0] r_burst;
    fvls_pkg::t_result [2:0] n_burst;
    logic [1:0]              r_bcnt;
    logic [1:0]              n_count;

    // Master-side output register.
    logic              r_out_v;
    fvls_pkg::t_result r_out;

    logic out_move;
    logic burst_free;
    logic proc;
    logic cfg_wr;

    assign base   = {r_base_hi, 16'h0000};
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == fvls_pkg::REG_BASE) ? base : {24'h000000, r_id};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id      <= 8'h00;
            r_base_hi <= 16'h0001;
        end else if (cfg_wr) begin
            if (paddr[2] == fvls_pkg::REG_ID) begin
                r_id <= pwdata[7:0];
            end else begin
                r_base_hi <= pwdata[31:16];
            end
        end
    end

    // A burst entry moves to the output register whenever that register is empty or
    // its result is being taken. The held item is worked once the burst has no
    // entry left after this cycle, so load bytes, which give no command, stream
    // through at one per cycle.
    assign out_move   = (r_bcnt != 2'd0) && (!r_out_v || m_tready);
    assign burst_free = (r_bcnt == 2'd0) || ((r_bcnt == 2'd1) && out_move);
    assign proc       = r_in_v && burst_free;
    assign s_tready   = !r_in_v || proc;

    fvls_step #(
        .DATASET_BYTES (DATASET_BYTES),
        .PAGE_BYTES    (PAGE_BYTES),
        .SECTOR_BYTES  (SECTOR_BYTES),
        .FIRST_SLOT    (FIRST_SLOT),
        .LAST_SLOT     (LAST_SLOT)
    ) u_step (
        .i_state (r_state),
        .i_item  (r_in),
        .i_id    (r_id),
        .i_base  (base),
        .o_state (n_state),
        .o_res   (n_burst),
        .o_count (n_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (s_tready) begin
            r_in_v <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in <= '{action: s_tuser, page_byte: s_tdata, last_byte: s_tlast};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{cur_slot: SW'(FIRST_SLOT), needs_init: 1'b1, scan_index: '0,
                         phase: fvls_pkg::PH_ID, scan_slot: '0};
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    // The burst count is control state; the entries themselves need no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= 2'd0;
        end else if (proc) begin
            r_bcnt <= n_count;
        end else if (out_move) begin
            r_bcnt <= r_bcnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_burst <= n_burst;
        end else if (out_move) begin
            r_burst[0] <= r_burst[1];
            r_burst[1] <= r_burst[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_move) begin
            r_out_v <= 1'b1;
        end else if (m_tready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_move) begin
            r_out <= r_burst[0];
        end
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = {5'b00000, r_out.slot, r_out.data, r_out.addr};
    assign m_tuser  = r_out.cmd;
    assign m_tlast  = r_out.last;

endmodule

/* rtl/fvls_checker.sv */
// Port-level checker of the flash version log slot keeper, bound to its top level.
`include "flash_version_log_slots_unit_assert.svh"

module fvls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result stays on the port unchanged.
    `FVLS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Reads, rejects and dataset writes always close the commands of their input.
    `FVLS_ASSERT_IMP(a_final_cmd, m_tvalid && (m_tuser == fvls_pkg::CMD_READ || m_tuser == fvls_pkg::CMD_REJECT || m_tuser == fvls_pkg::CMD_DATA), m_tlast, "closing command without last")

    // Erase, header and track writes are always followed by a dataset write.
    `FVLS_ASSERT_IMP(a_lead_cmd, m_tvalid && (m_tuser == fvls_pkg::CMD_ERASE || m_tuser == fvls_pkg::CMD_HEADER || m_tuser == fvls_pkg::CMD_TRACK), !m_tlast, "leading command marked last")

    // The header write carries the fixed header byte.
    `FVLS_ASSERT_IMP(a_header_byte, m_tvalid && m_tuser == fvls_pkg::CMD_HEADER, m_tdata[39:32] == fvls_pkg::HEADER_BYTE, "header write with wrong byte")

endmodule

bind flash_version_log_slots_unit fvls_checker u_fvls_checker (.*);

/* tb/sv/tb_flash_version_log_slots_unit.sv */
// Self-checking testbench for the flash version log slot keeper.
`timescale 1ns / 100ps

module tb_flash_version_log_slots_unit;
    import fvls_pkg::*;

    // Geometry of the block as built with its default parameters.
    localparam int DATASET_BYTES = DATASET_BYTES_DEF;
    localparam int PAGE_BYTES    = PAGE_BYTES_DEF;
    localparam int SECTOR_BYTES  = SECTOR_BYTES_DEF;
    localparam int FIRST_SLOT    = FIRST_SLOT_DEF;
    localparam int LAST_SLOT     = LAST_SLOT_DEF;
    localparam int TRACK_START   = (FIRST_SLOT / 8 < 1) ? 1 : FIRST_SLOT / 8;
    localparam logic [IDX_W-1:0] FINAL_INDEX = IDX_W'(PAGE_BYTES - 1);

    // Margin that settle() waits after the last owed result has left.
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int MAX_IDLE      = 18;
    localparam int RANDOM_ROWS   = 30;

    // Kinds of stimulus step: single saves, whole or damaged tracking pages,
    // register writes, and a full drain of the result stream.
    typedef enum {
        OP_SAVE,
        OP_PAGE,
        OP_BAD_ID,
        OP_NO_PREFIX,
        OP_BLANK,
        OP_SHORT,
        OP_LONG,
        OP_PARTIAL,
        OP_NOISE,
        OP_CFG_ID,
        OP_CFG_BASE,
        OP_DRAIN
    } t_op;

    typedef struct {
        t_op         op;
        logic [31:0] arg;      // slot, length, extra bytes or register value
        bit          typed;    // the load's result below is used instead of the prediction
        t_result     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] page_byte
    logic        s_tuser  = 1'b0;    // [0] action (0 load byte, 1 save)
    logic        s_tlast  = 1'b0;    // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;            // [31:0] address, [39:32] data_byte, [50:40] slot
    logic [2:0]  m_tuser;            // [2:0] command
    logic        m_tlast;            // last
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    flash_version_log_slots_unit uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Shadow copy of the keeper: registers, current slot and the page scan.
    logic [7:0]        kp_id;
    logic [31:0]       kp_base;
    logic [SLOT_W-1:0] kp_cur;
    logic              kp_fresh;     // no save or good load since reset
    logic [IDX_W-1:0]  trk_index;
    t_phase            trk_phase;
    logic [SLOT_W-1:0] trk_slot;

    t_result new_cmds[$];       // commands caused by the item just transferred
    t_result pending_cmds[$];   // commands still owed by the block, oldest first
    t_row    plan[$];
    logic [7:0] page_buf [0:PAGE_BYTES+3];

    bit      use_typed = 1'b0;
    t_result typed_cmd;
    bit      snd_quiet = 1'b0;
    bit      rcv_quiet = 1'b0;
    int      rcv_hold  = 0;
    int      rcv_stall;
    int      errors       = 0;
    int      items_sent   = 0;
    int      cycles       = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: the slowest legal run is several times shorter than this.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic int idle_cycles(bit quiet);
        return quiet ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic t_result mk_cmd(t_cmd c, logic [31:0] a, logic [7:0] d,
                                       logic [SLOT_W-1:0] s, logic l);
        t_result r;
        r.cmd  = c;
        r.addr = a;
        r.data = d;
        r.slot = s;
        r.last = l;
        return r;
    endfunction

    function automatic void clear_scan();
        trk_index = '0;
        trk_phase = PH_ID;
        trk_slot  = '0;
    endfunction

    // One tracking page byte at page offset k. The written slots must be a run
    // of cleared bits from the first data slot on; the byte where that run ends
    // fixes the last written slot, and only 0xFF may follow it.
    function automatic void track_byte(logic [IDX_W-1:0] k, logic [7:0] b);
        int lead;
        int pos;
        case (trk_phase)
            PH_ID: begin
                trk_phase = (b == kp_id) ? PH_ZEROS : PH_BAD;
            end
            PH_ZEROS: begin
                if (int'(k) >= TRACK_START && b != 8'h00) begin
                    lead = 0;
                    while (lead < 7 && b[7-lead] == 1'b0)
                        lead++;
                    pos = int'(k) * 8 + lead - 1;
                    if (pos < FIRST_SLOT || b != (ALL_ONES >> lead)) begin
                        trk_phase = PH_BAD;
                    end else begin
                        trk_slot  = pos[SLOT_W-1:0];
                        trk_phase = PH_ONES;
                    end
                end
            end
            PH_ONES: begin
                if (b != ALL_ONES)
                    trk_phase = PH_BAD;
            end
            default: ;
        endcase
    endfunction

    // Works out the commands one transferred item causes and advances the shadow state.
    function automatic void predict_keeper(logic act, logic [7:0] b, logic lst);
        logic [SLOT_W-1:0] pos;
        logic [31:0]       addr;
        new_cmds.delete();
        if (act) begin
            // A save drops any half-read page and moves on one slot, wrapping
            // at the end of the block; a save with no save or good load before it reuses slot 8.
            clear_scan();
            pos = kp_cur;
            if (!kp_fresh)
                pos = (pos < LAST_SLOT) ? pos + 1'b1 : SLOT_W'(FIRST_SLOT);
            kp_fresh = 1'b0;
            addr = kp_base + 32'(pos) * DATASET_BYTES;
            if (pos == FIRST_SLOT) begin
                new_cmds.push_back(mk_cmd(CMD_ERASE, kp_base, 8'h00, pos, 1'b0));
                new_cmds.push_back(mk_cmd(CMD_HEADER, kp_base, HEADER_BYTE, pos, 1'b0));
            end else begin
                if (addr % 32'(SECTOR_BYTES) == 0)
                    new_cmds.push_back(mk_cmd(CMD_ERASE, addr, 8'h00, pos, 1'b0));
                new_cmds.push_back(mk_cmd(CMD_TRACK, kp_base + 32'(pos / 8),
                                          ALL_ONES >> (pos % 8 + 1), pos, 1'b0));
            end
            new_cmds.push_back(mk_cmd(CMD_DATA, addr, 8'h00, pos, 1'b1));
            kp_cur = pos;
        end else if (!lst) begin
            // A byte past the final offset without the end mark spoils the page.
            if (trk_index >= FINAL_INDEX) begin
                trk_phase = PH_BAD;
            end else begin
                track_byte(trk_index, b);
                trk_index++;
            end
        end else begin
            if (trk_index != FINAL_INDEX)
                trk_phase = PH_BAD;
            else
                track_byte(trk_index, b);
            if (trk_phase == PH_ONES || trk_phase == PH_ZEROS) begin
                // A page of nothing but zeros means the last slot is in use.
                pos = (trk_phase == PH_ONES) ? trk_slot : SLOT_W'(PAGE_BYTES * 8 - 1);
                kp_cur   = pos;
                kp_fresh = 1'b0;
                new_cmds.push_back(mk_cmd(CMD_READ, kp_base + 32'(pos) * DATASET_BYTES,
                                          8'h00, pos, 1'b1));
            end else begin
                new_cmds.push_back(mk_cmd(CMD_REJECT, kp_base, 8'h00, kp_cur, 1'b1));
            end
            clear_scan();
        end
    endfunction

    // Builds a well-formed tracking page whose last written slot is the given one.
    // The last slot of the block gives a page of zeros; bytes past the page are 0xFF.
    function automatic void fill_tracking(int slot);
        int kp;
        int lead;
        kp   = (slot + 1) / 8;
        lead = (slot + 1) % 8;
        page_buf[0] = kp_id;
        for (int k = 1; k <= PAGE_BYTES + 3; k++) begin
            if (k < kp)
                page_buf[k] = 8'h00;
            else if (k == kp)
                page_buf[k] = ALL_ONES >> lead;
            else
                page_buf[k] = ALL_ONES;
        end
    endfunction

    function automatic int random_slot();
        case ($urandom_range(0, 9))
            0:       return FIRST_SLOT;
            1:       return LAST_SLOT;
            default: return $urandom_range(FIRST_SLOT, LAST_SLOT);
        endcase
    endfunction

    // One transfer on the input stream. It is entered and left at a rising edge,
    // so tvalid stays high across back-to-back transfers without a second update.
    task automatic send_item(input logic act, input logic [7:0] b, input logic lst);
        int gap;
        gap = idle_cycles(snd_quiet);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        s_tlast  <= lst;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        items_sent++;
        predict_keeper(act, b, lst);
        if (use_typed && new_cmds.size() != 0) begin
            pending_cmds.push_back(typed_cmd);
        end else begin
            foreach (new_cmds[i])
                pending_cmds.push_back(new_cmds[i]);
        end
    endtask

    // Stops sending, waits for every owed command, then lets the pipeline empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write through the configuration port, then a read-back check.
    task automatic cfg_write(input logic idx, input logic [31:0] val);
        logic [31:0] want;
        settle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (idx == REG_ID)
            kp_id = val[7:0];
        else
            kp_base = {val[31:16], 16'h0000};
        want = (idx == REG_ID) ? {24'h0, kp_id} : kp_base;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata !== want) begin
            errors++;
            $display("%0t: register %0d read back, expected 0x%0h, got 0x%0h",
                     $time, idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Streams one tracking page, whole or damaged as the step kind says.
    task automatic run_page(input t_op op, input logic [31:0] arg);
        int len;
        bit has_last;
        logic lst;
        len      = PAGE_BYTES;
        has_last = 1'b1;
        case (op)
            OP_PAGE: begin
                fill_tracking(int'(arg));
            end
            OP_BAD_ID: begin
                fill_tracking(int'(arg));
                page_buf[0] = ~kp_id;
            end
            OP_NO_PREFIX: begin
                fill_tracking(int'(arg));
                page_buf[$urandom_range(1, PAGE_BYTES - 1)] = 8'($urandom);
            end
            OP_BLANK: begin
                // Id followed by nothing but 0xFF: no slot written at all.
                fill_tracking(FIRST_SLOT - 1);
            end
            OP_SHORT: begin
                fill_tracking(random_slot());
                len = int'(arg);
            end
            OP_LONG: begin
                fill_tracking(random_slot());
                len = PAGE_BYTES + int'(arg);
            end
            OP_PARTIAL: begin
                fill_tracking(random_slot());
                len      = int'(arg);
                has_last = 1'b0;
            end
            default: begin
                for (int k = 0; k < int'(arg); k++)
                    page_buf[k] = 8'($urandom);
                len      = int'(arg);
                has_last = 1'b0;
            end
        endcase
        for (int k = 0; k < len; k++) begin
            if (op == OP_NOISE)
                lst = ($urandom_range(0, 7) == 0);
            else
                lst = has_last && (k == len - 1);
            send_item(1'b0, page_buf[k], lst);
        end
    endtask

    task automatic run_row(input t_row row);
        use_typed = row.typed;
        typed_cmd = row.res;
        snd_quiet = ($urandom_range(0, 3) == 0);
        case (row.op)
            OP_SAVE:     send_item(1'b1, 8'($urandom), 1'($urandom));
            OP_CFG_ID:   cfg_write(REG_ID, row.arg);
            OP_CFG_BASE: cfg_write(REG_BASE, row.arg);
            OP_DRAIN:    settle();
            default:     run_page(row.op, row.arg);
        endcase
        use_typed = 1'b0;
    endtask

    function automatic void add_row(t_op op, logic [31:0] arg);
        plan.push_back('{op, arg, 1'b0, mk_cmd(CMD_REJECT, 32'h0, 8'h00, '0, 1'b0)});
    endfunction

    function automatic void add_typed(t_op op, logic [31:0] arg, t_result res);
        plan.push_back('{op, arg, 1'b1, res});
    endfunction

    // Result side: ready drops for a random stretch after each transfer,
    // and now and then switches to a run with no stalls at all.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            rcv_hold <= 0;
        end else if (m_tready) begin
            if (m_tvalid) begin
                if ($urandom_range(0, 15) == 0)
                    rcv_quiet <= !rcv_quiet;
                rcv_stall = idle_cycles(rcv_quiet);
                if (rcv_stall != 0) begin
                    m_tready <= 1'b0;
                    rcv_hold <= rcv_stall;
                end
            end
        end else if (rcv_hold <= 1) begin
            m_tready <= 1'b1;
            rcv_hold <= 0;
        end else begin
            rcv_hold <= rcv_hold - 1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    // Every result transfer is matched against the oldest owed command.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got command %0d addr 0x%0h",
                         $time, m_tuser, m_tdata[31:0]);
            end else begin
                want = pending_cmds.pop_front();
                check_field("command", 32'(want.cmd), 32'(m_tuser));
                check_field("address", want.addr, m_tdata[31:0]);
                check_field("data_byte", 32'(want.data), 32'(m_tdata[39:32]));
                check_field("slot", 32'(want.slot), 32'(m_tdata[50:40]));
                check_field("last", 32'(want.last), 32'(m_tlast));
                check_field("tdata padding", 32'h0, 32'(m_tdata[55:51]));
            end
        end
    end

    initial begin
        t_row row;
        int   pick;

        kp_id    = 8'h00;
        kp_base  = 32'h0001_0000;
        kp_cur   = SLOT_W'(FIRST_SLOT);
        kp_fresh = 1'b1;
        clear_scan();

        // Directed steps. The results typed in here follow directly from the
        // reset state, the register extremes or the reject rule.
        add_typed(OP_SHORT, 32'd1, mk_cmd(CMD_REJECT, 32'h0001_0000, 8'h00, 11'd8, 1'b1));
        add_row(OP_SAVE, 32'd0);                  // first save after reset: slot 8
        add_row(OP_SAVE, 32'd0);
        add_typed(OP_PAGE, 32'd2047,              // page of zeros: last slot
                  mk_cmd(CMD_READ, 32'h0001_FFE0, 8'h00, 11'd2047, 1'b1));
        add_row(OP_SAVE, 32'd0);                  // wraps back to the first slot
        add_typed(OP_PAGE, 32'd8, mk_cmd(CMD_READ, 32'h0001_0100, 8'h00, 11'd8, 1'b1));
        add_row(OP_PAGE, 32'd127);
        add_row(OP_SAVE, 32'd0);                  // slot 128 opens a new sector
        add_row(OP_CFG_ID, 32'h0000_00FF);
        add_typed(OP_BAD_ID, 32'd300,
                  mk_cmd(CMD_REJECT, 32'h0001_0000, 8'h00, 11'd128, 1'b1));
        add_row(OP_PAGE, 32'd1000);
        add_row(OP_CFG_BASE, 32'hFFFF_FFFF);      // low half is dropped
        add_row(OP_SAVE, 32'd0);
        add_typed(OP_PAGE, 32'd2046, mk_cmd(CMD_READ, 32'hFFFF_FFC0, 8'h00, 11'd2046, 1'b1));
        add_row(OP_SAVE, 32'd0);
        add_row(OP_SAVE, 32'd0);                  // past the last slot, back to slot 8
        add_typed(OP_LONG, 32'd1, mk_cmd(CMD_REJECT, 32'hFFFF_0000, 8'h00, 11'd8, 1'b1));
        add_typed(OP_BLANK, 32'd0, mk_cmd(CMD_REJECT, 32'hFFFF_0000, 8'h00, 11'd8, 1'b1));
        add_row(OP_NO_PREFIX, 32'd500);
        add_row(OP_PARTIAL, 32'd100);
        add_row(OP_SAVE, 32'd0);                  // abandons the half-read page
        add_row(OP_CFG_ID, 32'h0000_0000);
        add_row(OP_CFG_BASE, 32'h0000_0000);
        add_row(OP_PAGE, 32'd14);                 // run ends on the lowest bit of a byte
        add_row(OP_PAGE, 32'd15);                 // run ends on a byte boundary
        add_row(OP_DRAIN, 32'd0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i])
            run_row(plan[i]);

        // Random part: mostly saves and well-formed pages with random content,
        // the rest damaged pages, stray bytes and register changes.
        for (int r = 0; r < RANDOM_ROWS; r++) begin
            row.typed = 1'b0;
            row.res   = mk_cmd(CMD_REJECT, 32'h0, 8'h00, '0, 1'b0);
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                row.op = OP_CFG_ID;
                case ($urandom_range(0, 2))
                    0:       row.arg = 32'h0;
                    1:       row.arg = 32'h0000_00FF;
                    default: row.arg = $urandom;
                endcase
                if ($urandom_range(0, 1) == 1) begin
                    row.op = OP_CFG_BASE;
                    if (row.arg[7:0] == 8'hFF)
                        row.arg = 32'hFFFF_FFFF;
                    else if (row.arg != 32'h0)
                        row.arg = $urandom;
                end
            end else if (pick < 7) begin
                row.op  = OP_DRAIN;
                row.arg = 32'd0;
            end else if (pick < 42) begin
                row.op  = OP_SAVE;
                row.arg = 32'd0;
            end else if (pick < 75) begin
                row.op  = OP_PAGE;
                row.arg = random_slot();
            end else begin
                case ($urandom_range(0, 6))
                    0: begin row.op = OP_BAD_ID;    row.arg = random_slot(); end
                    1: begin row.op = OP_NO_PREFIX; row.arg = random_slot(); end
                    2: begin row.op = OP_BLANK;     row.arg = 32'd0; end
                    3: begin row.op = OP_SHORT;     row.arg = $urandom_range(1, 255); end
                    4: begin row.op = OP_LONG;      row.arg = $urandom_range(1, 3); end
                    5: begin row.op = OP_PARTIAL;   row.arg = $urandom_range(1, 255); end
                    default: begin row.op = OP_NOISE; row.arg = $urandom_range(1, 40); end
                endcase
            end
            run_row(row);
        end

        settle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
